>>> sv/gpop_pkg.sv
// Shared types and constants for the glyph program opcode parser.
// Used by glyph_program_opcode_parser; no other dependencies.
package gpop_pkg;

  // Default bound on completed non-jump instructions per glyph
  localparam int unsigned MaxInstructions = 65536;

  localparam int unsigned LenW   = 19;
  localparam int unsigned PhaseW = 4;
  localparam int unsigned KindW  = 3;
  localparam int unsigned StatW  = 3;
  localparam int unsigned JumpW  = 3;

  localparam logic [LenW-1:0] LenSat = '1;

  // Opcode bytes
  localparam logic [7:0] OpcPrefix01 = 8'h01;
  localparam logic [7:0] OpcRow1     = 8'hf8;
  localparam logic [7:0] OpcRow2     = 8'hf0;
  localparam logic [7:0] OpcMov8     = 8'h88;
  localparam logic [7:0] OpcModRm58  = 8'h58;
  localparam logic [7:0] OpcSize66   = 8'h66;
  localparam logic [7:0] OpcMov32    = 8'h89;
  localparam logic [7:0] OpcFstp     = 8'hdd;
  localparam logic [7:0] OpcModRm50  = 8'h50;
  localparam logic [7:0] OpcJump     = 8'he9;

  // Number of bytes that follow the jump opcode
  localparam logic [JumpW-1:0] JumpTail = 3'd4;

  // Match phases
  localparam logic [PhaseW-1:0] PhOpcode   = 4'd0;
  localparam logic [PhaseW-1:0] PhAfter01  = 4'd1;
  localparam logic [PhaseW-1:0] PhAfter88  = 4'd2;
  localparam logic [PhaseW-1:0] PhAfter66  = 4'd3;
  localparam logic [PhaseW-1:0] PhAfter6689 = 4'd4;
  localparam logic [PhaseW-1:0] PhAfter89  = 4'd5;
  localparam logic [PhaseW-1:0] PhAfterDd  = 4'd6;
  localparam logic [PhaseW-1:0] PhDisp     = 4'd7;
  localparam logic [PhaseW-1:0] PhJump     = 4'd8;

  // Operation kinds
  localparam logic [KindW-1:0] KindRow1   = 3'd0;
  localparam logic [KindW-1:0] KindRow2   = 3'd1;
  localparam logic [KindW-1:0] KindStore1 = 3'd2;
  localparam logic [KindW-1:0] KindStore2 = 3'd3;
  localparam logic [KindW-1:0] KindStore4 = 3'd4;
  localparam logic [KindW-1:0] KindStore8 = 3'd5;
  localparam logic [KindW-1:0] KindEnd    = 3'd6;

  // Status codes
  localparam logic [StatW-1:0] StOk      = 3'd0;
  localparam logic [StatW-1:0] StUnterm  = 3'd1;
  localparam logic [StatW-1:0] StUnsup   = 3'd2;
  localparam logic [StatW-1:0] StJumpTr  = 3'd3;
  localparam logic [StatW-1:0] StOpndTr  = 3'd4;
  localparam logic [StatW-1:0] StBound   = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [KindW-1:0]  op_kind;
    logic signed [7:0] displacement;
    logic [StatW-1:0]  status;
    logic [LenW-1:0]   program_length;
    logic              run_last;
  } out_t;

endpackage

>>> sv/glyph_program_opcode_parser.sv
// Glyph program opcode parser: byte-wise pattern matcher with a result queue.
// Depends on gpop_pkg.
//
// One program byte is taken per cycle while the input is not stalled. The byte
// is matched against the opcode patterns in the same cycle it is accepted, and
// its zero, one or two results are written into a four-entry result queue that
// drives the output channel, one result per cycle while the output is not
// stalled. A byte may yield two results (an operation followed by an end).
// Input stall rises while the queue holds more than two results, so the
// sustained rate is set by the output drain of one result per cycle.
// Bytes after the end of a glyph are dropped until a first byte.
module glyph_program_opcode_parser #(
  parameter int unsigned MAX_INSTRUCTIONS = gpop_pkg::MaxInstructions
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  gpop_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output gpop_pkg::out_t out_data_o
);

  localparam int unsigned CntW = $clog2(MAX_INSTRUCTIONS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_INSTRUCTIONS);

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  // Parser state
  logic [gpop_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [gpop_pkg::LenW-1:0]   bytes_q, bytes_d;
  logic [CntW-1:0]             icnt_q, icnt_d;
  logic [gpop_pkg::KindW-1:0]  pend_q, pend_d;
  logic [gpop_pkg::JumpW-1:0]  jseen_q, jseen_d;
  logic                        fin_q, fin_d;

  // Result queue
  gpop_pkg::out_t     q_mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]   q_cnt_q;

  logic           in_acc, out_acc;
  logic [1:0]     n_res;
  gpop_pkg::out_t res0, res1;

  // Working copies after a first byte has restarted the glyph
  logic [gpop_pkg::PhaseW-1:0] ph_cur;
  logic [CntW-1:0]             icnt_cur;
  logic [gpop_pkg::KindW-1:0]  pend_cur;
  logic [gpop_pkg::JumpW-1:0]  jseen_cur, jseen_inc;
  logic [gpop_pkg::LenW-1:0]   bytes_cur;
  logic                        op_done, jump_end;
  logic [gpop_pkg::KindW-1:0]  op_kind;
  logic [gpop_pkg::StatW-1:0]  err;
  logic [7:0]                  b;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign b       = in_data_i.data_byte;

  // Pattern matcher and result formation
  always_comb begin
    phase_d   = phase_q;
    bytes_d   = bytes_q;
    icnt_d    = icnt_q;
    pend_d    = pend_q;
    jseen_d   = jseen_q;
    fin_d     = fin_q;
    n_res     = 2'd0;
    res0      = '0;
    res1      = '0;
    ph_cur    = phase_q;
    icnt_cur  = icnt_q;
    pend_cur  = pend_q;
    jseen_cur = jseen_q;
    bytes_cur = bytes_q;
    op_done   = 1'b0;
    jump_end  = 1'b0;
    op_kind   = gpop_pkg::KindRow1;
    err       = gpop_pkg::StOk;
    jseen_inc = '0;

    if (in_acc && (in_data_i.first_byte || !fin_q)) begin
      if (in_data_i.first_byte) begin
        ph_cur    = gpop_pkg::PhOpcode;
        icnt_cur  = '0;
        pend_cur  = '0;
        jseen_cur = '0;
        bytes_cur = '0;
      end
      fin_d     = 1'b0;
      bytes_d   = (bytes_cur != gpop_pkg::LenSat) ? bytes_cur + 1'b1 : bytes_cur;
      icnt_d    = icnt_cur;
      pend_d    = pend_cur;
      jseen_d   = jseen_cur;
      phase_d   = ph_cur;
      jseen_inc = jseen_cur + 1'b1;

      case (ph_cur)
        gpop_pkg::PhOpcode: begin
          case (b)
            gpop_pkg::OpcPrefix01: phase_d = gpop_pkg::PhAfter01;
            gpop_pkg::OpcMov8:     phase_d = gpop_pkg::PhAfter88;
            gpop_pkg::OpcSize66:   phase_d = gpop_pkg::PhAfter66;
            gpop_pkg::OpcMov32:    phase_d = gpop_pkg::PhAfter89;
            gpop_pkg::OpcFstp:     phase_d = gpop_pkg::PhAfterDd;
            gpop_pkg::OpcJump: begin
              phase_d = gpop_pkg::PhJump;
              jseen_d = '0;
            end
            default:               err = gpop_pkg::StUnsup;
          endcase
        end
        gpop_pkg::PhAfter01: begin
          if (b == gpop_pkg::OpcRow1) begin
            op_done = 1'b1;
            op_kind = gpop_pkg::KindRow1;
          end else if (b == gpop_pkg::OpcRow2) begin
            op_done = 1'b1;
            op_kind = gpop_pkg::KindRow2;
          end else begin
            err = gpop_pkg::StUnsup;
          end
        end
        gpop_pkg::PhAfter88: begin
          if (b == gpop_pkg::OpcModRm58) begin
            phase_d = gpop_pkg::PhDisp;
            pend_d  = gpop_pkg::KindStore1;
          end else begin
            err = gpop_pkg::StUnsup;
          end
        end
        gpop_pkg::PhAfter66: begin
          if (b == gpop_pkg::OpcMov32) phase_d = gpop_pkg::PhAfter6689;
          else                         err = gpop_pkg::StUnsup;
        end
        gpop_pkg::PhAfter6689: begin
          if (b == gpop_pkg::OpcModRm58) begin
            phase_d = gpop_pkg::PhDisp;
            pend_d  = gpop_pkg::KindStore2;
          end else begin
            err = gpop_pkg::StUnsup;
          end
        end
        gpop_pkg::PhAfter89: begin
          if (b == gpop_pkg::OpcModRm58) begin
            phase_d = gpop_pkg::PhDisp;
            pend_d  = gpop_pkg::KindStore4;
          end else begin
            err = gpop_pkg::StUnsup;
          end
        end
        gpop_pkg::PhAfterDd: begin
          if (b == gpop_pkg::OpcModRm50) begin
            phase_d = gpop_pkg::PhDisp;
            pend_d  = gpop_pkg::KindStore8;
          end else begin
            err = gpop_pkg::StUnsup;
          end
        end
        gpop_pkg::PhDisp: begin
          op_done = 1'b1;
          op_kind = pend_cur;
        end
        default: begin
          // jump tail: count bytes after the jump opcode
          jseen_d = jseen_inc;
          if (jseen_inc >= gpop_pkg::JumpTail) jump_end = 1'b1;
        end
      endcase

      if (jump_end) begin
        res0.op_kind        = gpop_pkg::KindEnd;
        res0.program_length = bytes_d;
        res0.run_last       = 1'b1;
        n_res   = 2'd1;
        fin_d   = 1'b1;
        phase_d = gpop_pkg::PhOpcode;
      end else if (err != gpop_pkg::StOk) begin
        res0.op_kind  = gpop_pkg::KindEnd;
        res0.status   = err;
        res0.run_last = 1'b1;
        n_res   = 2'd1;
        fin_d   = 1'b1;
        phase_d = gpop_pkg::PhOpcode;
      end else if (op_done) begin
        phase_d           = gpop_pkg::PhOpcode;
        res0.op_kind      = op_kind;
        res0.displacement = (ph_cur == gpop_pkg::PhDisp) ? b : 8'sd0;
        icnt_d            = icnt_cur + 1'b1;
        res1.op_kind      = gpop_pkg::KindEnd;
        res1.run_last     = 1'b1;
        if (icnt_d >= CntMax) begin
          res1.status = gpop_pkg::StBound;
          n_res       = 2'd2;
          fin_d       = 1'b1;
        end else if (in_data_i.final_byte) begin
          res1.status = gpop_pkg::StUnterm;
          n_res       = 2'd2;
          fin_d       = 1'b1;
        end else begin
          res0.run_last = 1'b1;
          n_res         = 2'd1;
        end
      end else if (in_data_i.final_byte) begin
        res0.op_kind  = gpop_pkg::KindEnd;
        res0.run_last = 1'b1;
        if (phase_d == gpop_pkg::PhDisp)      res0.status = gpop_pkg::StOpndTr;
        else if (phase_d == gpop_pkg::PhJump) res0.status = gpop_pkg::StJumpTr;
        else                                  res0.status = gpop_pkg::StUnsup;
        n_res   = 2'd1;
        fin_d   = 1'b1;
        phase_d = gpop_pkg::PhOpcode;
      end
    end
  end

  // Parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= gpop_pkg::PhOpcode;
      bytes_q <= '0;
      icnt_q  <= '0;
      pend_q  <= '0;
      jseen_q <= '0;
      fin_q   <= 1'b1;
    end else begin
      phase_q <= phase_d;
      bytes_q <= bytes_d;
      icnt_q  <= icnt_d;
      pend_q  <= pend_d;
      jseen_q <= jseen_d;
      fin_q   <= fin_d;
    end
  end

  // Result queue: up to two pushes and one pop per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      q_cnt_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(n_res);
      rd_ptr_q <= rd_ptr_q + QPtrW'(out_acc);
      q_cnt_q  <= q_cnt_q + QCntW'(n_res) - QCntW'(out_acc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) q_mem_q[wr_ptr_q] <= res0;
    if (n_res == 2'd2) q_mem_q[wr_ptr_q + 1'b1] <= res1;
  end

  assign out_valid_o = (q_cnt_q != '0);
  assign out_data_o  = q_mem_q[rd_ptr_q];
  assign in_stall_o  = (q_cnt_q > QCntW'(QDepth - 2));

  // Checks
  a_q_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q <= QCntW'(QDepth))
    else $error("result queue overflow");

  a_err_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != gpop_pkg::StOk)
      |-> (out_data_o.op_kind == gpop_pkg::KindEnd) && out_data_o.run_last)
    else $error("error result without end kind");

  a_len_only_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.program_length != '0)
      |-> (out_data_o.op_kind == gpop_pkg::KindEnd)
          && (out_data_o.status == gpop_pkg::StOk))
    else $error("program length on non-end result");

  a_drop_when_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && fin_q && !in_data_i.first_byte |=> q_cnt_q <= $past(q_cnt_q))
    else $error("result from ignored byte");

  a_end_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_res != 2'd0) && (phase_d == gpop_pkg::PhJump) |-> !fin_d)
    else $error("jump phase left in finished glyph");

endmodule
